>>> hw/rtl/ple_pkg.sv
// Shared types, codes and constants for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LCOUNT_W   = 10;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;

  // Fan-in of one stage of the readout OR tree
  localparam int unsigned FAN_IN = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_REM_FRONT = 3'd3,
    ACT_REM_BACK  = 3'd4,
    ACT_REM_AT    = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Broadcast to every cell for the accepted item
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  // Registered stages needed to OR-reduce depth leaves, at least one
  function automatic int unsigned tree_levels(input int unsigned depth);
    int unsigned span;
    int unsigned lvl;
    span = 1;
    lvl  = 0;
    while (span < depth) begin
      span = span * FAN_IN;
      lvl  = lvl + 1;
    end
    return (lvl < 1) ? 1 : lvl;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ple_cell.sv
// One list cell: holds a word, shifts from a neighbor on insert or removal.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell import ple_pkg::*; #(
  parameter int unsigned W     = 32,
  parameter int unsigned PW    = 10,
  parameter int unsigned INDEX = 0
) (
  input  wire logic          clk_i,
  input  wire cell_ctl_t     ctl_i,
  input  wire logic [PW-1:0] pos_i,
  input  wire logic [W-1:0]  value_i,
  input  wire logic [W-1:0]  left_i,
  input  wire logic [W-1:0]  right_i,
  output logic [W-1:0]       data_o,
  output logic [W-1:0]       hit_o
);

  localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

  logic [W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (MY_IDX > pos_i) begin
        data_d = left_i;
      end else if (MY_IDX == pos_i) begin
        data_d = value_i;
      end
    end else if (ctl_i.rem) begin
      if (MY_IDX >= pos_i) begin
        data_d = right_i;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // word leaving the list, zero when this cell is not the removal target
  assign hit_o  = (ctl_i.rem && (MY_IDX == pos_i)) ? data_q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/ple_readout.sv
// Registered OR tree that gathers the removed word from the cell row.
`timescale 1ns / 1ps
`default_nettype none

module ple_readout import ple_pkg::*; #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned W     = 32
) (
  input  wire logic         clk_i,
  input  wire logic         load_i,
  input  wire logic [W-1:0] leaf_i [DEPTH],
  output logic [W-1:0]      word_o
);

  localparam int unsigned LEVELS = tree_levels(DEPTH);

  logic [W-1:0] node_q [LEVELS+1][DEPTH];
  logic [W-1:0] node_d [LEVELS+1][DEPTH];

  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      node_d[0][j] = load_i ? leaf_i[j] : node_q[0][j];
    end
    for (int l = 1; l <= LEVELS; l++) begin
      for (int j = 0; j < DEPTH; j++) begin
        node_d[l][j] = '0;
        for (int k = 0; k < FAN_IN; k++) begin
          if (j * FAN_IN + k < DEPTH) begin
            node_d[l][j] = node_d[l][j] | node_q[l-1][j*FAN_IN+k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
  end

  assign word_o = node_q[LEVELS][0];

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_engine.sv
// Top level: ordered word list as a row of shifting cells with stream ports.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      action, position, value
//  m_axis    out  m_axis_tvalid/tready      removed_value, removed_valid,
//                                           status, list_count
//
// Each accepted item updates the whole cell row in the edge that accepts it:
// every cell loads the new word, its left or right neighbor, or holds.
// The removed word is gathered by a registered OR tree of fan-in 8; the
// hits are loaded into the leaf register when the item is accepted and then
// pass through every registered level of the tree before the result is taken.
// s_axis_tready is low while an item is in flight; a finished result waits
// in the output register, and the next item is taken meanwhile.
// Reset clears the count and the handshake state; cell contents are left
// as they are and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned DEPTH      = 512,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // s_axis_tdata: action [2:0], position [12:3], value [44:13], zero [47:45]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // m_axis_tdata: removed_value [31:0], removed_valid [32], status [34:33],
  //               list_count [44:35], zero [47:45]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready
);

  localparam int unsigned CW     = $clog2(DEPTH + 1);      // count width
  localparam int unsigned PW     = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned LEVELS = tree_levels(DEPTH);
  localparam int unsigned LW     = $clog2(LEVELS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // ---------------------------------------------------------------- input
  action_e            in_act;
  logic [POS_W-1:0]   in_pos;
  logic [VALUE_W-1:0] in_value;
  logic               accept;

  assign in_act   = action_e'(s_axis_tdata[ACTION_W-1:0]);
  assign in_pos   = s_axis_tdata[ACTION_W +: POS_W];
  assign in_value = s_axis_tdata[ACTION_W+POS_W +: VALUE_W];

  // ---------------------------------------------------------------- state
  logic [CW-1:0]  count_q, count_d;
  logic           pend_q;          // item in the readout tree
  logic [LW-1:0]  cnt_q;           // tree stages still to go
  status_e        pend_status_q;
  logic           pend_valid_q;
  logic [CW-1:0]  pend_count_q;

  logic           out_valid_q;
  logic [VALUE_W-1:0]  out_word_q;
  logic           out_rvalid_q;
  status_e        out_status_q;
  logic [LCOUNT_W-1:0] out_count_q;

  // ---------------------------------------------------------------- decode
  cell_ctl_t      ctl;
  status_e        status;
  logic [PW-1:0]  pos_ext, cnt_ext, tgt;
  logic           is_full, is_empty;

  assign pos_ext  = PW'(in_pos);
  assign cnt_ext  = PW'(count_q);
  assign is_full  = (count_q == FULL_COUNT);
  assign is_empty = (count_q == '0);

  always_comb begin
    ctl    = '0;
    status = ST_OK;
    tgt    = '0;
    case (in_act)
      ACT_INS_FRONT: begin
        if (is_full) status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      ACT_INS_BACK: begin
        tgt = cnt_ext;
        if (is_full) status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      ACT_INS_AT: begin
        tgt = pos_ext;
        if (is_full) status = ST_FULL;
        else if (pos_ext > cnt_ext) status = ST_BADPOS;
        else ctl.ins = 1'b1;
      end
      ACT_REM_FRONT: begin
        if (is_empty) status = ST_EMPTY;
        else ctl.rem = 1'b1;
      end
      ACT_REM_BACK: begin
        tgt = cnt_ext - PW'(1);
        if (is_empty) status = ST_EMPTY;
        else ctl.rem = 1'b1;
      end
      ACT_REM_AT: begin
        tgt = pos_ext;
        if (is_empty) status = ST_EMPTY;
        else if (pos_ext >= cnt_ext) status = ST_BADPOS;
        else ctl.rem = 1'b1;
      end
      default: begin
        // unused codes: no change, status ok
      end
    endcase
    if (!accept) ctl = '0;
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins) count_d = count_q + CW'(1);
    else if (ctl.rem) count_d = count_q - CW'(1);
  end

  // ---------------------------------------------------------------- cell row
  logic [63:0]           value_wide;
  logic [ELEM_WIDTH-1:0] value_elem;
  logic [CW-1:0]         cell_pos;
  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_hit  [DEPTH];

  assign value_wide = 64'(in_value);
  assign value_elem = value_wide[ELEM_WIDTH-1:0];
  assign cell_pos   = tgt[CW-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ple_cell #(
      .W     (ELEM_WIDTH),
      .PW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .pos_i   (cell_pos),
      .value_i (value_elem),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // ---------------------------------------------------------------- readout
  logic [ELEM_WIDTH-1:0] tree_word;
  logic [63:0]           tree_wide;

  ple_readout #(
    .DEPTH (DEPTH),
    .W     (ELEM_WIDTH)
  ) u_readout (
    .clk_i  (clk_i),
    .load_i (accept),
    .leaf_i (cell_hit),
    .word_o (tree_word)
  );

  assign tree_wide = 64'(tree_word);

  // ---------------------------------------------------------------- handshake
  logic done, xfer;

  assign s_axis_tready = !pend_q;
  assign accept        = s_axis_tvalid && !pend_q;
  assign done          = pend_q && (cnt_q == '0);
  assign xfer          = done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_q <= 1'b1;
        cnt_q  <= LW'(LEVELS);
      end else begin
        if (pend_q && (cnt_q != '0)) cnt_q <= cnt_q - LW'(1);
        if (xfer) pend_q <= 1'b0;
      end
      if (xfer) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // payload side registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= status;
      pend_valid_q  <= ctl.rem;
      pend_count_q  <= count_d;
    end
    if (xfer) begin
      out_word_q   <= tree_wide[VALUE_W-1:0];
      out_rvalid_q <= pend_valid_q;
      out_status_q <= pend_status_q;
      out_count_q  <= LCOUNT_W'(pend_count_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_status_q, out_rvalid_q, out_word_q};

endmodule

`default_nettype wire
